// ===== design/double_hash_key_value_table_assert.svh =====
// assertion macros for the hash table
`ifndef DOUBLE_HASH_KEY_VALUE_TABLE_ASSERT_SVH
`define DOUBLE_HASH_KEY_VALUE_TABLE_ASSERT_SVH

// implication checked on every clock edge outside reset
`define DHKV_ASSERT_IMPL(label, clk, rst_n, lhs, rhs, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (lhs) |-> (rhs)) \
        else $error(msg);

// implication checked in the next cycle
`define DHKV_ASSERT_NEXT(label, clk, rst_n, lhs, rhs, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (lhs) |=> (rhs)) \
        else $error(msg);

`endif

// ===== design/dhkv_pkg.sv =====
`default_nettype none
package dhkv_pkg;
    localparam int TableSlots  = 251;
    localparam int MaxKeyBytes = 8;
    localparam int ValueBits   = 32;
    localparam int KeyBits     = 64;
    localparam int LenBits     = 4;
    localparam int CountBits   = 8;
    localparam int ValOutBits  = 32;
    localparam int PrimeHome   = 151;
    localparam int PrimeStep   = 163;

    localparam logic [1:0] OP_UPSERT = 2'd0;
    localparam logic [1:0] OP_DELETE = 2'd1;
    localparam logic [1:0] OP_SEARCH = 2'd2;

    localparam logic [1:0] MARK_EMPTY   = 2'd0;
    localparam logic [1:0] MARK_LIVE    = 2'd1;
    localparam logic [1:0] MARK_DELETED = 2'd2;

    typedef struct packed {
        logic [1:0]         op;
        logic [KeyBits-1:0] key_bytes;
        logic [LenBits-1:0] key_length;
        logic [31:0]        value_in;
    } req_t;

    typedef struct packed {
        logic                  found;
        logic [ValOutBits-1:0] value_out;
        logic                  status;
        logic [CountBits-1:0]  entry_count;
    } rsp_t;
endpackage
`default_nettype wire

// ===== design/dhkv_if.sv =====
`default_nettype none
interface dhkv_if #(parameter int W = 1);
    logic         valid;
    logic         ready;
    logic [W-1:0] data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

// ===== design/dhkv_hash.sv =====
`default_nettype none
// polynomial hash in horner order from the last key byte, one key bit per cycle
// per bit: run = 2*run + key bit, then run += acc when the base bit is set, both mod m
// both bases run in parallel
module dhkv_hash #(
    parameter int SLOTS     = dhkv_pkg::TableSlots,
    parameter int KEY_BYTES = dhkv_pkg::MaxKeyBytes,
    parameter int IW        = $clog2(SLOTS)
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          start,
    input  wire logic [dhkv_pkg::KeyBits-1:0]  key,
    input  wire logic [dhkv_pkg::LenBits-1:0]  len,
    output logic                               done,
    output logic [IW-1:0]                      home,
    output logic [IW-1:0]                      step
);
    import dhkv_pkg::*;

    localparam int SM1 = SLOTS - 1;
    localparam logic [IW:0] M1_C = (IW+1)'(SLOTS);
    localparam logic [IW:0] M2_C = (IW+1)'(SM1);
    localparam logic [7:0]  BH   = 8'(PrimeHome);
    localparam logic [7:0]  BS   = 8'(PrimeStep);

    logic                 busy_reg, busy_next;
    logic                 load_reg, load_next;
    logic [LenBits-1:0]   rem_reg, rem_next;
    logic [2:0]           bit_reg, bit_next;
    logic [IW-1:0]        acc1_reg, acc1_next, acc2_reg, acc2_next;   // bytes done so far
    logic [IW-1:0]        run1_reg, run1_next, run2_reg, run2_next;   // within one byte
    logic [LenBits-1:0]   bsel;
    logic [7:0]           byte_cur;
    logic                 kbit;
    logic [IW-1:0]        n1, n2;

    // one double-and-add step, each half brought back below m by one subtraction
    function automatic logic [IW-1:0] mac_bit(input logic [IW-1:0] run, input logic kb,
                                              input logic add, input logic [IW-1:0] acc,
                                              input logic [IW:0] m);
        logic [IW:0] d;
        logic [IW:0] e;
        begin
            d = {run, kb};
            if (d >= m)
            begin
                d = d - m;
            end
            e = add ? (d + {1'b0, acc}) : d;
            if (e >= m)
            begin
                e = e - m;
            end
            return IW'(e);
        end
    endfunction

    always_comb
    begin
        bsel      = rem_reg - LenBits'(1);
        byte_cur  = key[bsel[2:0]*8 +: 8];
        kbit      = byte_cur[bit_reg];
        n1        = mac_bit(run1_reg, kbit, BH[bit_reg], acc1_reg, M1_C);
        n2        = mac_bit(run2_reg, kbit, BS[bit_reg], acc2_reg, M2_C);
        busy_next = busy_reg;
        load_next = load_reg;
        rem_next  = rem_reg;
        bit_next  = bit_reg;
        acc1_next = acc1_reg;
        acc2_next = acc2_reg;
        run1_next = run1_reg;
        run2_next = run2_reg;
        done      = 1'b0;
        if (start)
        begin
            busy_next = 1'b1;
            load_next = 1'b1;
            acc1_next = '0;
            acc2_next = '0;
            run1_next = '0;
            run2_next = '0;
        end
        else if (load_reg)
        begin
            // key and length are registered by now
            load_next = 1'b0;
            rem_next  = (len > LenBits'(KEY_BYTES)) ? LenBits'(KEY_BYTES) : len;
            bit_next  = 3'd7;
        end
        else if (busy_reg)
        begin
            if (rem_reg == '0)
            begin
                busy_next = 1'b0;
                done      = 1'b1;
            end
            else if (bit_reg == 3'd0)
            begin
                acc1_next = n1;
                acc2_next = n2;
                run1_next = '0;
                run2_next = '0;
                rem_next  = rem_reg - LenBits'(1);
                bit_next  = 3'd7;
            end
            else
            begin
                run1_next = n1;
                run2_next = n2;
                bit_next  = bit_reg - 3'd1;
            end
        end
    end

    assign home = acc1_reg;
    assign step = acc2_reg + IW'(1);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            load_reg <= 1'b0;
            rem_reg  <= '0;
            bit_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            load_reg <= load_next;
            rem_reg  <= rem_next;
            bit_reg  <= bit_next;
        end
    end

    always_ff @(posedge clk)
    begin
        acc1_reg <= acc1_next;
        acc2_reg <= acc2_next;
        run1_reg <= run1_next;
        run2_reg <= run2_next;
    end
endmodule
`default_nettype wire

// ===== design/double_hash_key_value_table.sv =====
// operation: the key is hashed from the accepted word, then one slot is read and compared
// per probe, at most TABLE_SLOTS probes (hashing takes one key bit per cycle)
// operations are taken one at a time and a word is accepted only in idle; an unread
// output word holds the next result in ST_OUT until the output register is read
// reset: rst_n asynchronous, control and count clear; slot marks cleared by a
// sweep over all TABLE_SLOTS slots after reset, during which no word is accepted
`default_nettype none
module double_hash_key_value_table #(
    parameter int TABLE_SLOTS   = dhkv_pkg::TableSlots,
    parameter int MAX_KEY_BYTES = dhkv_pkg::MaxKeyBytes,
    parameter int VALUE_BITS    = dhkv_pkg::ValueBits
) (
    input wire logic clk,
    input wire logic rst_n,
    dhkv_if.sink     in_ch,
    dhkv_if.source   out_ch
);
    import dhkv_pkg::*;
    `include "double_hash_key_value_table_assert.svh"

    localparam int IW = $clog2(TABLE_SLOTS);
    localparam logic [IW-1:0] SLOTS_C = IW'(TABLE_SLOTS);
    localparam int ENT_W = KeyBits + LenBits + VALUE_BITS;

    // sequencer states
    localparam logic [2:0] ST_CLEAR = 3'd0;
    localparam logic [2:0] ST_IDLE  = 3'd1;
    localparam logic [2:0] ST_HASH  = 3'd2;
    localparam logic [2:0] ST_READ  = 3'd3;
    localparam logic [2:0] ST_EVAL  = 3'd4;
    localparam logic [2:0] ST_OUT   = 3'd5;

    // memories: marks and entry payload, registered reads
    logic [1:0]       mark_mem [TABLE_SLOTS];
    logic [ENT_W-1:0] ent_mem  [TABLE_SLOTS];
    logic [1:0]       mark_rd;
    logic [ENT_W-1:0] ent_rd;
    logic             mark_we, ent_we;
    logic [IW-1:0]    wr_addr;
    logic [1:0]       mark_wd;
    logic [ENT_W-1:0] ent_wd;

    logic [2:0]       st_reg, st_next;
    logic [IW-1:0]    ptr_reg, ptr_next;       // clear sweep index / probe slot
    logic [IW-1:0]    step_reg, step_next;
    logic [IW:0]      tries_reg, tries_next;
    logic [1:0]       op_reg, op_next;
    logic [KeyBits-1:0] key_reg, key_next;
    logic [LenBits-1:0] len_reg, len_next;
    logic [VALUE_BITS-1:0] val_reg, val_next;
    logic [CountBits-1:0]  cnt_reg, cnt_next;
    logic             ovalid_reg, ovalid_next;
    rsp_t             rsp_reg, rsp_next;       // output word
    rsp_t             res_reg, res_next;       // finished result waiting for the output

    req_t             req;
    logic [LenBits-1:0] len_c;
    logic [KeyBits-1:0] key_c;
    logic             hash_start, hash_done;
    logic [IW-1:0]    h_home, h_step;
    logic [IW:0]      nxt_sum;
    logic [IW-1:0]    nxt_idx;
    logic             key_eq, take;
    logic [KeyBits-1:0]    rd_key;
    logic [LenBits-1:0]    rd_len;
    logic [VALUE_BITS-1:0] rd_val;

    assign req = req_t'(in_ch.data);

    // clamp the length and zero unused key bytes
    always_comb
    begin
        len_c = (req.key_length > LenBits'(MAX_KEY_BYTES)) ? LenBits'(MAX_KEY_BYTES)
                                                           : req.key_length;
        for (int b = 0; b < MaxKeyBytes; b++)
        begin
            key_c[b*8 +: 8] = (LenBits'(b) < len_c) ? req.key_bytes[b*8 +: 8] : 8'd0;
        end
    end

    dhkv_hash #(.SLOTS(TABLE_SLOTS), .KEY_BYTES(MAX_KEY_BYTES), .IW(IW)) u_hash (
        .clk   (clk),
        .rst_n (rst_n),
        .start (hash_start),
        .key   (key_reg),
        .len   (len_reg),
        .done  (hash_done),
        .home  (h_home),
        .step  (h_step)
    );

    assign {rd_key, rd_len, rd_val} = ent_rd;
    assign key_eq  = (rd_len == len_reg) && (rd_key == key_reg);
    assign nxt_sum = {1'b0, ptr_reg} + {1'b0, step_reg};
    assign nxt_idx = (nxt_sum >= {1'b0, SLOTS_C}) ? IW'(nxt_sum - {1'b0, SLOTS_C})
                                                  : IW'(nxt_sum);
    // the probe stops here
    assign take = (mark_rd == MARK_EMPTY)
               || (mark_rd == MARK_DELETED && op_reg == OP_UPSERT)
               || (mark_rd == MARK_LIVE && key_eq);

    assign in_ch.ready  = (st_reg == ST_IDLE);
    assign out_ch.valid = ovalid_reg;
    assign out_ch.data  = rsp_reg;

    always_comb
    begin
        st_next     = st_reg;
        ptr_next    = ptr_reg;
        step_next   = step_reg;
        tries_next  = tries_reg;
        op_next     = op_reg;
        key_next    = key_reg;
        len_next    = len_reg;
        val_next    = val_reg;
        cnt_next    = cnt_reg;
        ovalid_next = ovalid_reg;
        rsp_next    = rsp_reg;
        res_next    = res_reg;
        hash_start  = 1'b0;
        mark_we     = 1'b0;
        ent_we      = 1'b0;
        wr_addr     = ptr_reg;
        mark_wd     = MARK_EMPTY;
        ent_wd      = {key_reg, len_reg, val_reg};
        if (ovalid_reg && out_ch.ready)
        begin
            ovalid_next = 1'b0;
        end
        unique case (st_reg)
            ST_CLEAR:
            begin
                mark_we = 1'b1;
                if (ptr_reg == SLOTS_C - IW'(1))
                begin
                    st_next = ST_IDLE;
                end
                else
                begin
                    ptr_next = ptr_reg + IW'(1);
                end
            end
            ST_IDLE:
            begin
                if (in_ch.valid && in_ch.ready)
                begin
                    op_next  = req.op;
                    key_next = key_c;
                    len_next = len_c;
                    val_next = VALUE_BITS'(req.value_in);
                    if (req.op == OP_UPSERT || req.op == OP_DELETE || req.op == OP_SEARCH)
                    begin
                        st_next = ST_HASH;
                    end
                    else
                    begin
                        // unknown op: answer with the current count
                        res_next = '{found: 1'b0, value_out: '0, status: 1'b0,
                                     entry_count: cnt_reg};
                        st_next  = ST_OUT;
                    end
                end
            end
            ST_HASH:
            begin
                if (!hash_start && hash_done)
                begin
                    ptr_next   = h_home;
                    step_next  = h_step;
                    tries_next = '0;
                    st_next    = ST_READ;
                end
            end
            ST_READ:
            begin
                st_next = ST_EVAL;
            end
            ST_EVAL:
            begin
                res_next = '{found: 1'b0, value_out: '0, status: 1'b0,
                             entry_count: cnt_reg};
                if (take)
                begin
                    st_next = ST_OUT;
                    if (op_reg == OP_UPSERT)
                    begin
                        ent_we = 1'b1;
                        if (mark_rd == MARK_LIVE)
                        begin
                            ent_wd = {rd_key, rd_len, val_reg};
                            res_next.found = 1'b1;
                        end
                        else
                        begin
                            mark_we  = 1'b1;
                            mark_wd  = MARK_LIVE;
                            cnt_next = cnt_reg + CountBits'(1);
                            res_next.entry_count = cnt_next;
                        end
                    end
                    else if (mark_rd == MARK_LIVE)
                    begin
                        res_next.found = 1'b1;
                        if (op_reg == OP_DELETE)
                        begin
                            mark_we  = 1'b1;
                            mark_wd  = MARK_DELETED;
                            cnt_next = cnt_reg - CountBits'(1);
                            res_next.entry_count = cnt_next;
                        end
                        else
                        begin
                            res_next.value_out = ValOutBits'(rd_val);
                        end
                    end
                end
                else if (tries_reg == (IW+1)'(TABLE_SLOTS - 1))
                begin
                    res_next.status = 1'b1;
                    st_next = ST_OUT;
                end
                else
                begin
                    tries_next = tries_reg + (IW+1)'(1);
                    ptr_next   = nxt_idx;
                    st_next    = ST_READ;
                end
            end
            ST_OUT:
            begin
                // wait here while the output register still holds an unread word
                if (!ovalid_reg || out_ch.ready)
                begin
                    rsp_next    = res_reg;
                    ovalid_next = 1'b1;
                    st_next     = ST_IDLE;
                end
            end
            default:
            begin
                st_next = ST_IDLE;
            end
        endcase
        if (st_reg == ST_IDLE && st_next == ST_HASH)
        begin
            hash_start = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg      <= ST_CLEAR;
            ptr_reg     <= '0;
            cnt_reg     <= '0;
            ovalid_reg  <= 1'b0;
        end
        else
        begin
            st_reg      <= st_next;
            ptr_reg     <= ptr_next;
            cnt_reg     <= cnt_next;
            ovalid_reg  <= ovalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        step_reg  <= step_next;
        tries_reg <= tries_next;
        op_reg    <= op_next;
        key_reg   <= key_next;
        len_reg   <= len_next;
        val_reg   <= val_next;
        rsp_reg   <= rsp_next;
        res_reg   <= res_next;
    end

    // slot memories
    always_ff @(posedge clk)
    begin
        if (mark_we)
        begin
            mark_mem[wr_addr] <= mark_wd;
        end
        if (ent_we)
        begin
            ent_mem[wr_addr] <= ent_wd;
        end
        mark_rd <= mark_mem[ptr_reg];
        ent_rd  <= ent_mem[ptr_reg];
    end

    `DHKV_ASSERT_IMPL(a_ready_idle, clk, rst_n, in_ch.ready, st_reg == ST_IDLE,
        "ready outside idle")
    `DHKV_ASSERT_IMPL(a_one_write, clk, rst_n, mark_we && st_reg != ST_CLEAR,
        st_reg == ST_EVAL, "mark write outside evaluation")
    `DHKV_ASSERT_NEXT(a_out_hold, clk, rst_n, out_ch.valid && !out_ch.ready,
        out_ch.valid && $stable(out_ch.data), "result dropped")
    `DHKV_ASSERT_IMPL(a_tries, clk, rst_n, st_reg == ST_EVAL,
        tries_reg < (IW+1)'(TABLE_SLOTS), "probe count overrun")
endmodule
`default_nettype wire
